FILE: sv/multi_roi_pixel_mask_assert.svh
// Assertion macros shared by the pixel mask RTL.
`ifndef MULTI_ROI_PIXEL_MASK_ASSERT_SVH
`define MULTI_ROI_PIXEL_MASK_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define MRPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrpm: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define MRPM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrpm: next-cycle check failed");

`else

`define MRPM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MRPM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: sv/mrpm_pkg.sv
// Shared types and constants for the multi-rectangle pixel mask.
`timescale 1ns / 1ps

package mrpm_pkg;

   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int NUM_REGIONS_DEF = 4;
   localparam int PIXEL_BITS_DEF  = 16;

   // rectangle registers present on the CSR port
   localparam int CFG_REGIONS = 4;

   localparam int PIX_W      = 16;
   localparam int ROW_W      = 12;
   localparam int FW_W       = 13;
   localparam int RCNT_W     = 3;
   localparam int COORD_W    = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   localparam reg_idx_type REG_FRAME_WIDTH  = 3'd0;
   localparam reg_idx_type REG_REGION_COUNT = 3'd1;
   localparam reg_idx_type REG_FILL_VALUE   = 3'd2;
   localparam reg_idx_type REG_REGION_A     = 3'd3;
   localparam reg_idx_type REG_REGION_B     = 3'd4;
   localparam reg_idx_type REG_REGION_C     = 3'd5;
   localparam reg_idx_type REG_REGION_D     = 3'd6;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 13'd512;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             kept;
   } rsp_payload_type;

   // data riding along the cell chain (column travels separately, its width is a parameter)
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [ROW_W-1:0] row;
      logic             hit;
   } cell_tag_type;

endpackage

FILE: sv/mrpm_csr.sv
// Configuration register file with APB-style access for the pixel mask.
`timescale 1ns / 1ps

module mrpm_csr import mrpm_pkg::*; #(
   parameter int NUM_REGIONS = NUM_REGIONS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready,
   output logic [FW_W-1:0]         frame_width_ff,
   output logic [RCNT_W-1:0]       region_count_ff,
   output logic [PIX_W-1:0]        fill_value_ff,
   output logic [CSR_DATA_W-1:0]   region_ff [NUM_REGIONS]
);

   reg_idx_type reg_idx;
   reg_idx_type slot;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign slot    = reg_idx - REG_REGION_A;
   assign wr_en   = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         region_count_ff <= '0;
         fill_value_ff   <= '0;
         for (int k = 0; k < NUM_REGIONS; k++) begin
            region_ff[k] <= '0;
         end
      end else if (wr_en) begin
         case (reg_idx)
            REG_FRAME_WIDTH: begin
               frame_width_ff <= pwdata[FW_W-1:0];
            end
            REG_REGION_COUNT: begin
               region_count_ff <= pwdata[RCNT_W-1:0];
            end
            REG_FILL_VALUE: begin
               fill_value_ff <= pwdata[PIX_W-1:0];
            end
            REG_REGION_A, REG_REGION_B, REG_REGION_C, REG_REGION_D: begin
               for (int k = 0; k < NUM_REGIONS; k++) begin
                  if (k < CFG_REGIONS && int'(slot) == k) begin
                     region_ff[k] <= pwdata;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_FRAME_WIDTH:  prdata = CSR_DATA_W'(frame_width_ff);
         REG_REGION_COUNT: prdata = CSR_DATA_W'(region_count_ff);
         REG_FILL_VALUE:   prdata = CSR_DATA_W'(fill_value_ff);
         REG_REGION_A, REG_REGION_B, REG_REGION_C, REG_REGION_D: begin
            for (int k = 0; k < NUM_REGIONS; k++) begin
               if (k < CFG_REGIONS && int'(slot) == k) begin
                  prdata = region_ff[k];
               end
            end
         end
         default: prdata = '0;
      endcase
   end

endmodule

FILE: sv/mrpm_raster.sv
// Raster position tracker: column and row of each accepted pixel.
`timescale 1ns / 1ps

module mrpm_raster import mrpm_pkg::*; #(
   parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             frame_start,
   input  logic [FW_W-1:0]  frame_width,
   output logic [COL_W-1:0] cur_col,
   output logic [ROW_W-1:0] cur_row
);

   // wide enough for frame_width, MAX_WIDTH and column + 1
   localparam int LIM_W = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [LIM_W-1:0] fw_ext, max_ext, limit, col_inc;
   logic             wrap;

   // frame start forces this pixel to the origin
   assign cur_col = frame_start ? '0 : col_ff;
   assign cur_row = frame_start ? '0 : row_ff;

   assign fw_ext  = LIM_W'(frame_width);
   assign max_ext = LIM_W'(MAX_WIDTH);
   assign limit   = (fw_ext < max_ext) ? fw_ext : max_ext;
   assign col_inc = LIM_W'(cur_col) + LIM_W'(1);
   assign wrap    = col_inc >= limit;

   assign col_in = wrap ? '0 : col_inc[COL_W-1:0];
   assign row_in = wrap ? cur_row + ROW_W'(1) : cur_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: sv/mrpm_cell.sv
// One chain cell: tests the passing pixel against a single rectangle.
`timescale 1ns / 1ps

module mrpm_cell import mrpm_pkg::*; #(
   parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  logic [COL_W-1:0]      up_col,
   input  cell_tag_type          up_tag,
   output logic                  up_ready,
   input  logic [CSR_DATA_W-1:0] rect,
   input  logic                  enable,
   output logic                  dn_valid,
   output logic [COL_W-1:0]      dn_col,
   output cell_tag_type          dn_tag,
   input  logic                  dn_ready
);

   logic               valid_ff;
   logic [COL_W-1:0]   col_ff;
   cell_tag_type       tag_ff, tag_in;
   logic [COORD_W:0]   x_lo, x_hi, y_lo, y_hi, c_ext, r_ext;
   logic               rect_hit;

   // 17-bit sums so right and bottom edges never wrap
   assign x_lo  = {1'b0, rect[15:0]};
   assign y_lo  = {1'b0, rect[31:16]};
   assign x_hi  = {1'b0, rect[15:0]}  + {1'b0, rect[47:32]};
   assign y_hi  = {1'b0, rect[31:16]} + {1'b0, rect[63:48]};
   assign c_ext = (COORD_W + 1)'(up_col);
   assign r_ext = (COORD_W + 1)'(up_tag.row);

   assign rect_hit = (c_ext >= x_lo) && (c_ext < x_hi) && (r_ext >= y_lo) && (r_ext < y_hi);

   always_comb begin
      tag_in     = up_tag;
      tag_in.hit = up_tag.hit | (enable & rect_hit);
   end

   // stage takes new data when empty or when its content moves on
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         col_ff <= up_col;
         tag_ff <= tag_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_col   = col_ff;
   assign dn_tag   = tag_ff;

endmodule

FILE: sv/multi_roi_pixel_mask.sv
// Top level of the multi-rectangle pixel mask.
//
// Usage:
//  - req channel carries one pixel per transaction (pixel_in, frame_start);
//    rsp channel returns one result per transaction (pixel_out, kept).
//  - A transaction moves on an edge with valid high and stall low.
//  - frame_start puts its pixel at column 0, row 0; the column wraps at
//    min(frame_width, MAX_WIDTH) and the row then advances modulo 4096.
//  - Each rectangle register feeds one cell of a chain; a pixel walks the
//    chain one cell per cycle while no stall holds it, collecting a hit flag as it goes.
//  - Path: an accepted pixel is registered in each cell in turn; the last cell's register drives rsp.
//  - Throughput: one pixel per clock while rsp_stall is low, set by the one-cell-per-cycle chain.
//  - Stalls: each cell holds its transaction while the next one is full and
//    stalled; empty cells still fill, so req_stall only rises once every
//    cell holds a pixel and rsp_stall is high.
//  - Reset (synchronous) empties the chain, clears column and row, and
//    returns the registers to frame_width 512, everything else zero.
//  - Registers are written through the APB port at 8 * index and must be
//    changed only while no pixel is in flight.
`timescale 1ns / 1ps

`include "multi_roi_pixel_mask_assert.svh"

module multi_roi_pixel_mask import mrpm_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int NUM_REGIONS = NUM_REGIONS_DEF,
   parameter int PIXEL_BITS  = PIXEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   // register access
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int COL_W     = $clog2(MAX_WIDTH);
   // pixels are cut to PIXEL_BITS, and never beyond the 16-bit field
   localparam int KEEP_BITS = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
   localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((17'd1 << KEEP_BITS) - 17'd1);

   logic [FW_W-1:0]       frame_width;
   logic [RCNT_W-1:0]     region_count;
   logic [PIX_W-1:0]      fill_value;
   logic [CSR_DATA_W-1:0] region [NUM_REGIONS];
   logic [NUM_REGIONS-1:0] region_en;

   logic                  req_accept;
   logic [COL_W-1:0]      cur_col;
   logic [ROW_W-1:0]      cur_row;

   // chain links: index k feeds cell k, index NUM_REGIONS is the result register
   logic                  stg_valid [NUM_REGIONS+1];
   logic                  stg_ready [NUM_REGIONS+1];
   logic [COL_W-1:0]      stg_col   [NUM_REGIONS+1];
   cell_tag_type          stg_tag   [NUM_REGIONS+1];

   logic [PIX_W-1:0]      pixel_sel;

   mrpm_csr #(
      .NUM_REGIONS (NUM_REGIONS)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .frame_width_ff  (frame_width),
      .region_count_ff (region_count),
      .fill_value_ff   (fill_value),
      .region_ff       (region)
   );

   assign req_stall  = !stg_ready[0];
   assign req_accept = req_valid && !req_stall;

   mrpm_raster #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_accept),
      .frame_start (req_payload.frame_start),
      .frame_width (frame_width),
      .cur_col     (cur_col),
      .cur_row     (cur_row)
   );

   // head of the chain; with no rectangle in use every pixel starts as a hit
   assign stg_valid[0] = req_valid;
   assign stg_col[0]   = cur_col;
   assign stg_tag[0]   = '{pixel: req_payload.pixel_in, row: cur_row,
                           hit: (region_count == '0)};

   assign stg_ready[NUM_REGIONS] = !rsp_stall;

   for (genvar k = 0; k < NUM_REGIONS; k++) begin : g_cell
      // cells past region_count take part in timing but never hit
      assign region_en[k] = int'(region_count) > k;

      mrpm_cell #(
         .MAX_WIDTH (MAX_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[k]),
         .up_col   (stg_col[k]),
         .up_tag   (stg_tag[k]),
         .up_ready (stg_ready[k]),
         .rect     (region[k]),
         .enable   (region_en[k]),
         .dn_valid (stg_valid[k+1]),
         .dn_col   (stg_col[k+1]),
         .dn_tag   (stg_tag[k+1]),
         .dn_ready (stg_ready[k+1])
      );
   end

   // result: last cell's register drives the response directly
   assign rsp_valid             = stg_valid[NUM_REGIONS];
   assign pixel_sel             = stg_tag[NUM_REGIONS].hit ? stg_tag[NUM_REGIONS].pixel
                                                           : fill_value;
   assign rsp_payload.pixel_out = pixel_sel & PIX_MASK;
   assign rsp_payload.kept      = stg_tag[NUM_REGIONS].hit;

   // an accepted pixel lands in the first cell on the next edge
   `MRPM_ASSERT_NXT(a_accept_loads_cell0, clock, reset, req_accept, stg_valid[1])

   // a frame start pixel sits at the origin in the first cell
   `MRPM_ASSERT_NXT(a_frame_start_origin, clock, reset, req_accept && req_payload.frame_start, stg_col[1] == '0 && stg_tag[1].row == '0)

   // the chain holds no result right after reset
   `MRPM_ASSERT_NXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   // nothing enters while the head cell is full and blocked
   `MRPM_ASSERT_IMP(a_stall_blocks_entry, clock, reset, stg_valid[1] && !stg_ready[1], req_stall)

endmodule
